### src/cctbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctbd_pkg: shared types and color math for the 4x4 texture block decoder
// Endpoint word passed from front to back, YUV to RGB conversion and
// quarter-point interpolation.
// ----------------------------------------------------------------------------
package cctbd_pkg;

  localparam int unsigned YW = 10;  // endpoint Y, signed, spans -127..383
  localparam int unsigned CW = 12;  // working width of color math

  localparam logic [1:0] ModeReuseA = 2'd0;
  localparam logic [1:0] ModeReuseB = 2'd1;
  localparam logic [1:0] ModeDirect = 2'd2;
  localparam logic [1:0] ModeCenter = 2'd3;

  localparam logic [1:0] LastRow = 2'd3;
  localparam logic [7:0] Alpha   = 8'hFF;

  // one decoded block waiting for the back end
  typedef struct packed {
    logic signed [YW-1:0] my;
    logic signed [YW-1:0] ny;
    logic [7:0]           mu;
    logic [7:0]           mv;
    logic [7:0]           nu;
    logic [7:0]           nv;
    logic                 wide_idx;
    logic [31:0]          idx_bits;
  } entry_t;

  // four palette colors, {blue, green, red}
  typedef logic [3:0][23:0] palette_t;

  function automatic logic [7:0] clamp8(logic signed [CW-1:0] x);
    logic [7:0] res;
    if (x < 0)                res = 8'd0;
    else if (x > 12'sd255)    res = 8'd255;
    else                      res = x[7:0];
    return res;
  endfunction

  function automatic logic [23:0] yuv_to_rgb(logic signed [CW-1:0] y,
                                             logic [7:0] u, logic [7:0] v);
    logic signed [CW-1:0] s, h, g, r, b, ud, vd;
    s  = $signed({4'b0, u}) + $signed({4'b0, v}) - 12'sd256;
    // halve, truncating toward zero
    h  = s[CW-1] ? ((s + 12'sd1) >>> 1) : (s >>> 1);
    g  = y - h;
    vd = $signed({4'b0, v}) - 12'sd128;
    ud = $signed({4'b0, u}) - 12'sd128;
    r  = g + (vd <<< 1);
    b  = g + (ud <<< 1);
    return {clamp8(b), clamp8(g), clamp8(r)};
  endfunction

  // (3a + b) / 4, truncating toward zero
  function automatic logic signed [CW-1:0] interp(logic signed [CW-1:0] a,
                                                  logic signed [CW-1:0] b);
    logic signed [CW-1:0] t;
    t = a + a + a + b;
    return t[CW-1] ? ((t + 12'sd3) >>> 2) : (t >>> 2);
  endfunction

endpackage

### src/color_cell_texture_block_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_cell_texture_block_decoder: 4x4 color cell texture block decoder
// Takes 64-bit encoded blocks and delivers four rows of four RGBA pixels.
// ----------------------------------------------------------------------------
// Each accepted block yields four row words (row 0 first, last_row_o on row 3),
// one per cycle while pop is held, and the row emitter sets the sustained block
// rate. A new block can be taken in the cycle after the previous one while the
// queue is not full: the front decodes the mode and endpoints and updates the
// endpoint record at once, a two-entry queue absorbs stalls, and the back end
// builds the palette into a register and then streams rows. The first row of a
// block passes the queue, the palette register and the row register in order.
module color_cell_texture_block_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] block_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  row_number_o,
  output logic [31:0] pixel_zero_o,
  output logic [31:0] pixel_one_o,
  output logic [31:0] pixel_two_o,
  output logic [31:0] pixel_three_o,
  output logic        last_row_o
);

  cctbd_pkg::entry_t front_entry, q_entry;
  logic              accept, q_valid, q_pop;

  assign accept = push && !full;

  cctbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .block_word_i (block_word_i),
    .entry_o      (front_entry)
  );

  cctbd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (front_entry),
    .full_o    (full),
    .rd_en_i   (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (q_entry)
  );

  cctbd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_entry),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .row_number_o  (row_number_o),
    .pixel_zero_o  (pixel_zero_o),
    .pixel_one_o   (pixel_one_o),
    .pixel_two_o   (pixel_two_o),
    .pixel_three_o (pixel_three_o),
    .last_row_o    (last_row_o)
  );

  // rows of a block come out in order without gaps
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_row_o) |=>
      (!empty && row_number_o == 2'($past(row_number_o) + 2'd1)))
    else $error("row sequence broken inside a block");

  // a new block always starts at row 0
  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && last_row_o) |=> (empty || row_number_o == 2'd0))
    else $error("block did not start at row 0");

  // a stalled word holds its row
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(row_number_o)))
    else $error("row changed while stalled");

endmodule

### src/cctbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctbd_front: block classifier and endpoint builder
// Decodes the mode of each accepted block, builds the two YUV endpoints and
// keeps the endpoint record used by the reuse modes.
// ----------------------------------------------------------------------------
module cctbd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [63:0]         block_word_i,
  output cctbd_pkg::entry_t   entry_o
);

  logic [63:0] record_q, record_d;
  logic [31:0] hi, lo;
  logic        is64;
  logic [1:0]  mode;
  logic signed [cctbd_pkg::YW-1:0] my, ny, cy, dy;
  logic [7:0]  mu, mv, nu, nv;
  logic        wide_idx;
  logic signed [cctbd_pkg::YW:0] ysum;
  logic [cctbd_pkg::YW-1:0]      yspan;

  assign hi   = block_word_i[63:32];
  assign lo   = block_word_i[31:0];
  assign is64 = |hi;
  assign mode = is64 ? hi[31:30] : lo[31:30];

  always_comb begin
    my = '0; ny = '0; cy = '0; dy = '0;
    mu = '0; mv = '0; nu = '0; nv = '0;
    wide_idx = 1'b1;
    case (mode)
      cctbd_pkg::ModeReuseA, cctbd_pkg::ModeReuseB: begin
        my = $signed({2'b0, record_q[7:0]});
        mu = record_q[23:16];
        mv = record_q[31:24];
        ny = $signed({2'b0, record_q[39:32]});
        nu = record_q[55:48];
        nv = record_q[63:56];
      end
      cctbd_pkg::ModeDirect: begin
        if (is64) begin
          my = $signed({2'b0, hi[29:23], hi[29]});
          ny = $signed({2'b0, hi[22:16], hi[22]});
          mu = {hi[15:12], 4'b0};
          mv = {hi[11:8], 4'b0};
          nu = {hi[7:4], 4'b0};
          nv = {hi[3:0], 4'b0};
        end else begin
          my = $signed({2'b0, lo[29:27], lo[29:27], lo[29:28]});
          ny = $signed({2'b0, lo[26:24], lo[26:24], lo[26:25]});
          mu = {lo[23:22], 6'b0};
          mv = {lo[21:20], 6'b0};
          nu = {lo[19:18], 6'b0};
          nv = {lo[17:16], 6'b0};
          wide_idx = 1'b0;
        end
      end
      cctbd_pkg::ModeCenter: begin
        if (is64) begin
          cy = $signed({2'b0, hi[15:8]});
          dy = $signed({2'b0, hi[7:0]});
          mu = {hi[29:23], 1'b0};
          mv = {hi[22:16], 1'b0};
        end else begin
          // 4-bit values times 17 are the nibble repeated
          cy = $signed({2'b0, lo[29:26], lo[29:26]});
          dy = $signed({2'b0, lo[25:22], lo[25:22]});
          mu = {lo[21:19], 5'b0};
          mv = {lo[18:16], 5'b0};
          wide_idx = 1'b0;
        end
        my = cy - (dy >>> 1);
        ny = my + dy;
        nu = mu;
        nv = mv;
      end
      default: begin
        my = '0;
      end
    endcase
  end

  assign ysum  = {my[cctbd_pkg::YW-1], my} + {ny[cctbd_pkg::YW-1], ny};
  assign yspan = ny - my;

  always_comb begin
    record_d = record_q;
    if (accept_i) begin
      record_d = {nv, nu, yspan[7:0], ny[7:0], mv, mu, ysum[8:1], my[7:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_q <= '0;
    end else begin
      record_q <= record_d;
    end
  end

  assign entry_o = '{my: my, ny: ny, mu: mu, mv: mv, nu: nu, nv: nv,
                     wide_idx: wide_idx, idx_bits: lo};

endmodule

### src/cctbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctbd_queue: two-entry decoupling queue
// Holds decoded blocks between the front and the back end.
// ----------------------------------------------------------------------------
module cctbd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  cctbd_pkg::entry_t wr_data_i,
  output logic              full_o,
  input  logic              rd_en_i,
  output logic              valid_o,
  output cctbd_pkg::entry_t rd_data_o
);

  cctbd_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_wr, do_rd;

  assign full_o    = count_q == 2'd2;
  assign valid_o   = count_q != 2'd0;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_wr;
    rd_ptr_d = rd_ptr_q ^ do_rd;
    count_d  = count_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### src/cctbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctbd_back: palette builder and row emitter
// Converts endpoints and quarter points to RGB into a palette register, then
// emits the four pixel rows of the block from a row register.
// ----------------------------------------------------------------------------
module cctbd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cctbd_pkg::entry_t q_data_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [1:0]        row_number_o,
  output logic [31:0]       pixel_zero_o,
  output logic [31:0]       pixel_one_o,
  output logic [31:0]       pixel_two_o,
  output logic [31:0]       pixel_three_o,
  output logic              last_row_o
);

  // palette stage
  logic                  pal_valid_q, pal_valid_d;
  cctbd_pkg::palette_t   pal_q, pal_d;
  logic [31:0]           pal_bits_q;
  logic                  pal_wide_q;
  // row stage
  logic                  cur_valid_q, cur_valid_d;
  cctbd_pkg::palette_t   cur_pal_q;
  logic [31:0]           cur_bits_q;
  logic                  cur_wide_q;
  logic [1:0]            row_q, row_d;

  logic                  cur_adv, pal_free;
  logic signed [cctbd_pkg::CW-1:0] ym, yn, um, un, vm, vn;
  logic signed [cctbd_pkg::CW-1:0] y2, y3, u2, u3, v2, v3;
  logic [7:0]            row_byte;
  logic [3:0][1:0]       col_idx;
  logic [3:0][31:0]      pix;

  assign cur_adv  = !cur_valid_q || (pop_i && row_q == cctbd_pkg::LastRow);
  assign pal_free = !pal_valid_q || cur_adv;
  assign q_pop_o  = q_valid_i && pal_free;

  always_comb begin
    ym = cctbd_pkg::CW'(q_data_i.my);
    yn = cctbd_pkg::CW'(q_data_i.ny);
    um = $signed({4'b0, q_data_i.mu});
    un = $signed({4'b0, q_data_i.nu});
    vm = $signed({4'b0, q_data_i.mv});
    vn = $signed({4'b0, q_data_i.nv});
    y2 = cctbd_pkg::interp(ym, yn);
    y3 = cctbd_pkg::interp(yn, ym);
    u2 = cctbd_pkg::interp(um, un);
    u3 = cctbd_pkg::interp(un, um);
    v2 = cctbd_pkg::interp(vm, vn);
    v3 = cctbd_pkg::interp(vn, vm);
    pal_d[0] = cctbd_pkg::yuv_to_rgb(ym, q_data_i.mu, q_data_i.mv);
    pal_d[1] = cctbd_pkg::yuv_to_rgb(yn, q_data_i.nu, q_data_i.nv);
    pal_d[2] = cctbd_pkg::yuv_to_rgb(y2, u2[7:0], v2[7:0]);
    pal_d[3] = cctbd_pkg::yuv_to_rgb(y3, u3[7:0], v3[7:0]);
  end

  always_comb begin
    pal_valid_d = pal_valid_q;
    cur_valid_d = cur_valid_q;
    row_d       = row_q;
    if (pal_free) begin
      pal_valid_d = q_valid_i;
    end
    if (cur_adv) begin
      cur_valid_d = pal_valid_q;
      row_d       = '0;
    end else if (pop_i) begin
      row_d = row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_valid_q <= 1'b0;
      cur_valid_q <= 1'b0;
      row_q       <= '0;
    end else begin
      pal_valid_q <= pal_valid_d;
      cur_valid_q <= cur_valid_d;
      row_q       <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pal_q      <= pal_d;
      pal_bits_q <= q_data_i.idx_bits;
      pal_wide_q <= q_data_i.wide_idx;
    end
    if (cur_adv && pal_valid_q) begin
      cur_pal_q  <= pal_q;
      cur_bits_q <= pal_bits_q;
      cur_wide_q <= pal_wide_q;
    end
  end

  // byte r holds row r for 2-bit indices, nibble r for 1-bit indices
  always_comb begin
    case (row_q)
      2'd0:    row_byte = cur_bits_q[7:0];
      2'd1:    row_byte = cur_bits_q[15:8];
      2'd2:    row_byte = cur_bits_q[23:16];
      default: row_byte = cur_bits_q[31:24];
    endcase
    for (int c = 0; c < 4; c++) begin
      if (cur_wide_q) begin
        col_idx[c] = row_byte[7-2*c -: 2];
      end else begin
        col_idx[c] = {1'b0, cur_bits_q[4*row_q + 3 - c]};
      end
      pix[c] = {cctbd_pkg::Alpha, cur_pal_q[col_idx[c]]};
    end
  end

  assign empty_o       = !cur_valid_q;
  assign row_number_o  = row_q;
  assign last_row_o    = row_q == cctbd_pkg::LastRow;
  assign pixel_zero_o  = pix[0];
  assign pixel_one_o   = pix[1];
  assign pixel_two_o   = pix[2];
  assign pixel_three_o = pix[3];

endmodule
